@@ hdl/ddoc_pkg.sv @@
// ---------------------------------------------------------------------------
// ddoc_pkg - shared definitions for the date day-offset converter
// Calendar constants, serial-number span, controller state type and the
// command/status bundles passed between controller and datapath.
// ---------------------------------------------------------------------------
package ddoc_pkg;

  // Supported calendar span and the substitute for an out-of-range year
  localparam int FIRST_YEAR  = 1900;
  localparam int LAST_YEAR   = 2099;
  localparam int REPAIR_YEAR = 2000;
  localparam int REPAIR_EFF  = (REPAIR_YEAR >= FIRST_YEAR && REPAIR_YEAR <= LAST_YEAR) ?
                               REPAIR_YEAR : FIRST_YEAR;

  // Days in years 1..n, worked out at elaboration
  localparam int N_BASE      = FIRST_YEAR - 1;
  localparam int DAYS_BASE   = 365 * N_BASE + N_BASE / 4 - N_BASE / 100 + N_BASE / 400;
  localparam int DAYS_LAST   = 365 * LAST_YEAR + LAST_YEAR / 4 - LAST_YEAR / 100
                               + LAST_YEAR / 400;
  localparam int SERIAL_MAX  = DAYS_LAST - DAYS_BASE;

  // Year counter phases for the first year of the span
  localparam int FIRST_C100  = FIRST_YEAR % 100;
  localparam int FIRST_C400  = FIRST_YEAR % 400;

  // Field widths
  localparam int YEAR_W      = 12;
  localparam int MON_W       = 4;
  localparam int DAY_W       = 5;
  localparam int OFF_W       = 18;
  localparam int SER_OUT_W   = 17;
  localparam int SER_W       = $clog2(SERIAL_MAX + 1);
  localparam int SUM_W       = ((SER_W > OFF_W) ? SER_W : OFF_W) + 2;
  localparam int YLEN_W      = 9;

  localparam logic [YLEN_W-1:0] DAYS_COMMON = YLEN_W'(365);
  localparam logic [YLEN_W-1:0] DAYS_LEAP   = YLEN_W'(366);

  // Month codes
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_YFWD,
    S_DFIX,
    S_MFWD,
    S_ADDD,
    S_SUM,
    S_YBACK,
    S_MBACK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;    // capture and repair a new transaction
    logic yr_init;    // restart year walk at the first year
    logic yr_fwd;     // add year length, advance year
    logic fix_day;    // repair the day against the month length
    logic mon_init;   // restart month walk at January
    logic mon_fwd;    // add month length, advance month
    logic add_day;    // finish the input serial
    logic do_sum;     // add offset and clamp
    logic yr_back;    // take year length off the remainder, advance year
    logic mon_back;   // take month length off the remainder, advance month
    logic load_out;   // move the finished result to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic yr_lt;       // walk year still below the requested year
    logic mon_lt;      // walk month still below the requested month
    logic rem_gt_ylen; // remainder spans past the current year
    logic rem_gt_mlen; // remainder spans past the current month
    logic out_full;    // output register holds an untaken result
  } dp_sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB:                          len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                          len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/ddoc_if.sv @@
// ---------------------------------------------------------------------------
// ddoc_if - handshake channels of the date day-offset converter
// Input channel carries the requested date and offset; output channel the
// serials and the shifted date.
// ---------------------------------------------------------------------------
interface ddoc_in_if import ddoc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [YEAR_W-1:0]       year_in;
  logic [MON_W-1:0]        month_in;
  logic [DAY_W-1:0]        day_in;
  logic signed [OFF_W-1:0] day_offset;

  modport source (output valid, year_in, month_in, day_in, day_offset, input ready);
  modport sink   (input valid, year_in, month_in, day_in, day_offset, output ready);
endinterface

interface ddoc_out_if import ddoc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SER_OUT_W-1:0] in_serial;
  logic [YEAR_W-1:0]    out_year;
  logic [MON_W-1:0]     out_month;
  logic [DAY_W-1:0]     out_day;
  logic [SER_OUT_W-1:0] out_serial;

  modport source (output valid, in_serial, out_year, out_month, out_day, out_serial,
                  input ready);
  modport sink   (input valid, in_serial, out_year, out_month, out_day, out_serial,
                  output ready);
endinterface

@@ hdl/ddoc_ctrl.sv @@
// ---------------------------------------------------------------------------
// ddoc_ctrl - sequencing controller
// Steps one transaction through the year and month walks of the datapath.
// ---------------------------------------------------------------------------
module ddoc_ctrl import ddoc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_YFWD;
      S_YFWD:  if (!sts.yr_lt) state_nxt = S_DFIX;
      S_DFIX:  state_nxt = S_MFWD;
      S_MFWD:  if (!sts.mon_lt) state_nxt = S_ADDD;
      S_ADDD:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_YBACK;
      S_YBACK: if (!sts.rem_gt_ylen) state_nxt = S_MBACK;
      S_MBACK: if (!sts.rem_gt_mlen) state_nxt = S_DONE;
      S_DONE:  if (!sts.out_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.yr_init = 1'b1;
        end
      end
      S_YFWD: begin
        cmd.yr_fwd = sts.yr_lt;
      end
      S_DFIX: begin
        cmd.fix_day  = 1'b1;
        cmd.mon_init = 1'b1;
      end
      S_MFWD: begin
        cmd.mon_fwd = sts.mon_lt;
      end
      S_ADDD: begin
        cmd.add_day = 1'b1;
      end
      S_SUM: begin
        cmd.do_sum  = 1'b1;
        cmd.yr_init = 1'b1;
      end
      S_YBACK: begin
        cmd.yr_back  = sts.rem_gt_ylen;
        cmd.mon_init = !sts.rem_gt_ylen;
      end
      S_MBACK: begin
        cmd.mon_back = sts.rem_gt_mlen;
      end
      S_DONE: begin
        cmd.load_out = !sts.out_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/ddoc_dp.sv @@
// ---------------------------------------------------------------------------
// ddoc_dp - datapath
// Input capture and repair, year/month walk counters, serial accumulator,
// offset adder with clamp, and the output register.
// ---------------------------------------------------------------------------
module ddoc_dp import ddoc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [YEAR_W-1:0]       year_in,
  input  logic [MON_W-1:0]        month_in,
  input  logic [DAY_W-1:0]        day_in,
  input  logic signed [OFF_W-1:0] day_offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SER_OUT_W-1:0]    in_serial,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MON_W-1:0]        out_month,
  output logic [DAY_W-1:0]        out_day,
  output logic [SER_OUT_W-1:0]    out_serial
);

  // Captured, repaired transaction
  logic [YEAR_W-1:0]       y_r;
  logic [MON_W-1:0]        m_r;
  logic [DAY_W-1:0]        d_r;
  logic signed [OFF_W-1:0] off_r;

  // Walk counters and accumulator
  logic [YEAR_W-1:0] yr_r;
  logic [6:0]        c100_r;
  logic [8:0]        c400_r;
  logic [MON_W-1:0]  mon_r;
  logic [SER_W-1:0]  acc_r;
  logic [SER_W-1:0]  s_in_r;
  logic [SER_W-1:0]  sum_r;

  // Output register
  logic                 out_valid_r;
  logic [SER_OUT_W-1:0] o_in_serial_r;
  logic [YEAR_W-1:0]    o_year_r;
  logic [MON_W-1:0]     o_month_r;
  logic [DAY_W-1:0]     o_day_r;
  logic [SER_OUT_W-1:0] o_serial_r;

  logic                    leap;
  logic [YLEN_W-1:0]       ylen;
  logic [DAY_W-1:0]        mlen;
  logic [DAY_W-1:0]        dfix_len;
  logic [YEAR_W-1:0]       y_fix;
  logic [MON_W-1:0]        m_fix;
  logic signed [SUM_W-1:0] sum_raw;
  logic [SER_W-1:0]        sum_clamp;

  function automatic logic signed [SUM_W-1:0] day_offset_ext(
      input logic signed [OFF_W-1:0] v);
    return {{(SUM_W-OFF_W){v[OFF_W-1]}}, v};
  endfunction

  // Leap rule from the running year counters
  assign leap     = ((yr_r[1:0] == 2'b00) && (c100_r != 7'd0)) || (c400_r == 9'd0);
  assign ylen     = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen     = month_days(mon_r, leap);
  assign dfix_len = month_days(m_r, leap);

  assign y_fix = ((year_in < YEAR_W'(FIRST_YEAR)) || (year_in > YEAR_W'(LAST_YEAR))) ?
                 YEAR_W'(REPAIR_EFF) : year_in;
  assign m_fix = ((month_in == 4'd0) || (month_in > MON_DEC)) ? MON_JAN : month_in;

  assign sum_raw = $signed({{(SUM_W-SER_W){1'b0}}, s_in_r})
                 + SUM_W'(day_offset_ext(off_r));

  always_comb begin
    if (sum_raw < $signed(SUM_W'(1))) begin
      sum_clamp = SER_W'(1);
    end else if (sum_raw > $signed(SUM_W'(SERIAL_MAX))) begin
      sum_clamp = SER_W'(SERIAL_MAX);
    end else begin
      sum_clamp = sum_raw[SER_W-1:0];
    end
  end

  always_comb begin
    sts.yr_lt       = yr_r < y_r;
    sts.mon_lt      = mon_r < m_r;
    sts.rem_gt_ylen = (acc_r > SER_W'(ylen)) && (yr_r < YEAR_W'(LAST_YEAR));
    sts.rem_gt_mlen = (acc_r > SER_W'(mlen)) && (mon_r < MON_DEC);
    sts.out_full    = out_valid_r && !out_ready;
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      y_r   <= y_fix;
      m_r   <= m_fix;
      d_r   <= day_in;
      off_r <= day_offset;
      acc_r <= '0;
    end
    if (cmd.yr_init) begin
      yr_r   <= YEAR_W'(FIRST_YEAR);
      c100_r <= 7'(FIRST_C100);
      c400_r <= 9'(FIRST_C400);
    end else if (cmd.yr_fwd || cmd.yr_back) begin
      yr_r   <= yr_r + 1'b1;
      c100_r <= (c100_r == 7'd99)  ? 7'd0 : c100_r + 1'b1;
      c400_r <= (c400_r == 9'd399) ? 9'd0 : c400_r + 1'b1;
    end
    if (cmd.yr_fwd) begin
      acc_r <= acc_r + SER_W'(ylen);
    end
    if (cmd.yr_back) begin
      acc_r <= acc_r - SER_W'(ylen);
    end
    if (cmd.fix_day) begin
      if ((d_r == 5'd0) || (d_r > dfix_len)) begin
        d_r <= 5'd1;
      end
    end
    if (cmd.mon_init) begin
      mon_r <= MON_JAN;
    end else if (cmd.mon_fwd || cmd.mon_back) begin
      mon_r <= mon_r + 1'b1;
    end
    if (cmd.mon_fwd) begin
      acc_r <= acc_r + SER_W'(mlen);
    end
    if (cmd.mon_back) begin
      acc_r <= acc_r - SER_W'(mlen);
    end
    if (cmd.add_day) begin
      s_in_r <= acc_r + SER_W'(d_r);
    end
    if (cmd.do_sum) begin
      sum_r <= sum_clamp;
      acc_r <= sum_clamp;
    end
  end

  // Output register: hold until taken, reload in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_in_serial_r <= SER_OUT_W'(s_in_r);
      o_year_r      <= yr_r;
      o_month_r     <= mon_r;
      o_day_r       <= acc_r[DAY_W-1:0];
      o_serial_r    <= SER_OUT_W'(sum_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign in_serial  = o_in_serial_r;
  assign out_year   = o_year_r;
  assign out_month  = o_month_r;
  assign out_day    = o_day_r;
  assign out_serial = o_serial_r;

endmodule

@@ hdl/date_day_offset_converter_top.sv @@
// ---------------------------------------------------------------------------
// date_day_offset_converter_top - Gregorian date shifter
// Repairs a date, gives its serial day number, adds a signed day offset and
// converts the clamped sum back to a date.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction carries year_in, month_in, day_in, day_offset.
//   out_ch : one transaction carries in_serial (repaired input date, day 1 is
//            1900-01-01), out_year, out_month, out_day and out_serial.
//   Every input transaction yields exactly one output transaction, in order.
// Timing:
//   A transaction walks years up from the first year to the repaired year
//   (one year per cycle), then months up to the repaired month, then walks
//   the clamped sum down by years and by months. One transaction is in
//   flight at a time; the sequencer returns to idle to accept the next.
// Reset:
//   rst_n is synchronous, active low; it empties the output register and
//   returns the sequencer to idle. No calendar state survives a transaction.
// Stall:
//   A finished result waits in the output register while in_ch stays open,
//   so the next transaction runs meanwhile; if its result is ready before
//   the previous one is taken, the sequencer holds until the register frees.
// ---------------------------------------------------------------------------
module date_day_offset_converter_top import ddoc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ddoc_in_if.sink    in_ch,
  ddoc_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  // Sequencer: walks one transaction through the datapath
  ddoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: repair, accumulate, clamp and hold the result
  ddoc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .year_in    (in_ch.year_in),
    .month_in   (in_ch.month_in),
    .day_in     (in_ch.day_in),
    .day_offset (in_ch.day_offset),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .in_serial  (out_ch.in_serial),
    .out_year   (out_ch.out_year),
    .out_month  (out_ch.out_month),
    .out_day    (out_ch.out_day),
    .out_serial (out_ch.out_serial)
  );

endmodule
